// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by the queue cell and the top level; depends on nothing else.
`default_nettype none

package spq_pkg;

    // Request kinds carried on the input tuser field.
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_POP     = 2'd1;
    localparam logic [1:0] KIND_UPGRADE = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
        logic upg;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/spq_first_match.sv =====
// Finds the first set bit of the upgrade match vector across the cell chain.
// Produces a mask of all cells up to and including that bit; uses no package.
`default_nettype none

module spq_first_match #(
    parameter int N = 64
) (
    input  wire logic [N-1:0] i_match,
    output logic      [N-1:0] o_upto_mask,
    output logic              o_found
);

    // m ^ (m - 1) sets every bit from zero through the lowest set bit.
    assign o_upto_mask = i_match ^ (i_match - N'(1));
    assign o_found     = |i_match;

endmodule

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: a tag and a priority with compare-and-shift logic.
// Depends on spq_pkg for the command struct.
`default_nettype none

module spq_cell #(
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire spq_pkg::t_cell_cmd       i_cmd,
    input  wire logic [TAG_BITS-1:0]      i_req_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_req_prio,
    input  wire logic                     i_occ,
    input  wire logic                     i_upto,
    input  wire logic                     i_left_above,
    input  wire logic [TAG_BITS-1:0]      i_left_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_left_prio,
    input  wire logic [TAG_BITS-1:0]      i_right_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_right_prio,
    output logic                          o_above,
    output logic                          o_match,
    output logic [TAG_BITS-1:0]           o_tag,
    output logic [PRIORITY_BITS-1:0]      o_prio,
    output logic [TAG_BITS-1:0]           o_tag_next,
    output logic [PRIORITY_BITS-1:0]      o_prio_next
);
    import spq_pkg::*;

    logic [TAG_BITS-1:0]      r_tag,  n_tag;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;

    // An empty slot counts as above any priority, so the flags form a
    // thermometer along the chain and the insert point is its first edge.
    assign o_above = !i_occ || (r_prio > i_req_prio);
    assign o_match = i_occ && o_above && (r_tag == i_req_tag);

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_cmd.ins) begin
            if (i_left_above) begin
                n_tag  = i_left_tag;
                n_prio = i_left_prio;
            end else if (o_above) begin
                n_tag  = i_req_tag;
                n_prio = i_req_prio;
            end
        end else if (i_cmd.pop) begin
            n_tag  = i_right_tag;
            n_prio = i_right_prio;
        end else if (i_cmd.upg) begin
            // Cells between the insert point and the matched entry shift by one.
            if (i_left_above && i_upto) begin
                n_tag  = i_left_tag;
                n_prio = i_left_prio;
            end else if (!i_left_above && o_above && i_occ) begin
                n_tag  = i_req_tag;
                n_prio = i_req_prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

    assign o_tag       = r_tag;
    assign o_prio      = r_prio;
    assign o_tag_next  = n_tag;
    assign o_prio_next = n_prio;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_with_upgrade.sv =====
// Top level of the sorted priority queue: request register, control and cell chain.
// Depends on spq_pkg, spq_cell and spq_first_match.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser holds the kind (insert, pop,
//   upgrade, clear) and tdata holds the tag and the priority. Each request
//   gives exactly one result transfer on the m_axis channel with the status,
//   the popped tag, the head entry after the request and the empty flag.
//   The block handles one request at a time. A request is registered in the
//   cycle it is accepted; the whole cell chain then compares and shifts once
//   the output register is free, and the result is written to that register
//   for m_axis. No new request is accepted until that result has been written,
//   so requests are taken one after another, each through the request register
//   and the single compare-and-shift pass of the chain.
//   If the receiver stalls, the finished result stays in the output register
//   and the next accepted request waits in the request register until that
//   result has been taken; s_axis_tready is low while a request is pending.
//   Reset empties the queue and drops any pending result; slot contents are
//   not cleared since only occupied slots are ever read.
`default_nettype none

module sorted_priority_queue_with_upgrade #(
    parameter int CAPACITY      = 64,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // tdata, from bit 0: tag, priority_req; zero padded to whole bytes.
    input  wire logic [((TAG_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: kind.
    input  wire logic [1:0]                              s_axis_tuser,

    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // tdata, from bit 0: status, popped_tag, head_tag, head_priority, is_empty;
    // zero padded to whole bytes.
    output logic [((3+2*TAG_BITS+PRIORITY_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import spq_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int OUT_W  = 3 + 2*TAG_BITS + PRIORITY_BITS;
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

    t_state r_state, n_state;

    logic [1:0]               r_req_kind;
    logic [TAG_BITS-1:0]      r_req_tag;
    logic [PRIORITY_BITS-1:0] r_req_prio;
    logic [CNT_W-1:0]         r_count, n_count;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    logic              accept, fire;
    logic              is_full, is_none;
    t_cell_cmd         cmd;

    logic [CAPACITY-1:0]      occ, above, match, upto;
    logic                     found;
    logic [TAG_BITS-1:0]      cell_tag      [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio     [CAPACITY];
    logic [TAG_BITS-1:0]      cell_tag_nxt  [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio_nxt [CAPACITY];

    logic [1:0]               status;
    logic [TAG_BITS-1:0]      popped, head_tag;
    logic [PRIORITY_BITS-1:0] head_prio;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign is_full = (r_count == CNT_W'(CAPACITY));
    assign is_none = (r_count == '0);

    always_comb begin
        cmd     = '0;
        if (fire) begin
            case (r_req_kind)
                KIND_INSERT:  cmd.ins = !is_full;
                KIND_POP:     cmd.pop = !is_none;
                KIND_UPGRADE: cmd.upg = !is_none && found;
                default:      cmd     = '0;
            endcase
        end
    end

    spq_first_match #(
        .N (CAPACITY)
    ) u_first_match (
        .i_match     (match),
        .o_upto_mask (upto),
        .o_found     (found)
    );

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam int LI = (gi == 0) ? 0 : gi - 1;
        localparam int RI = (gi == CAPACITY - 1) ? gi : gi + 1;

        assign occ[gi] = (CNT_W'(gi) < r_count);

        spq_cell #(
            .TAG_BITS      (TAG_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_req_tag    (r_req_tag),
            .i_req_prio   (r_req_prio),
            .i_occ        (occ[gi]),
            .i_upto       (upto[gi]),
            .i_left_above ((gi == 0) ? 1'b0 : above[LI]),
            .i_left_tag   (cell_tag[LI]),
            .i_left_prio  (cell_prio[LI]),
            .i_right_tag  (cell_tag[RI]),
            .i_right_prio (cell_prio[RI]),
            .o_above      (above[gi]),
            .o_match      (match[gi]),
            .o_tag        (cell_tag[gi]),
            .o_prio       (cell_prio[gi]),
            .o_tag_next   (cell_tag_nxt[gi]),
            .o_prio_next  (cell_prio_nxt[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        status  = ST_OK;
        popped  = '0;
        case (r_req_kind)
            KIND_INSERT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_POP: begin
                if (is_none) begin
                    status = ST_EMPTY;
                end else begin
                    popped  = cell_tag[0];
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_UPGRADE: begin
                if (is_none) begin
                    status = ST_EMPTY;
                end else if (!found) begin
                    status = ST_NOTFOUND;
                end
            end
            default: n_count = '0;
        endcase

        if (n_count != '0) begin
            head_tag  = cell_tag_nxt[0];
            head_prio = cell_prio_nxt[0];
        end else begin
            head_tag  = '0;
            head_prio = '0;
        end
        n_out_data = {(n_count == '0), head_prio, head_tag, popped, status};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  if (fire)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_kind <= s_axis_tuser;
            r_req_tag  <= s_axis_tdata[TAG_BITS-1:0];
            r_req_prio <= s_axis_tdata[TAG_BITS +: PRIORITY_BITS];
        end
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'(r_out_data);

endmodule

`default_nettype wire
